// ----- rtl/cmm_pkg.sv -----
// ----------------------------------------------------------------------------
// Colour matrix mixer package
// Shared widths, register indexes, configuration struct and arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cmm_pkg;

  localparam int NumChan   = 4;
  localparam int ChanW     = 8;
  localparam int CoefW     = 14;
  localparam int RowW      = NumChan * CoefW;
  localparam int ProdW     = 22;          // 255 * 9000 fits in 22 bits
  localparam int QuotW     = 12;          // 2295 at most after the divide
  localparam int SumW      = 14;          // four quotients, 9180 at most
  localparam int RecipW    = 23;
  localparam int RecipMulW = ProdW + RecipW;
  localparam int RecipSh   = 32;
  localparam int PaddrW    = 6;
  localparam int PdataW    = 64;
  localparam int IdxW      = 3;
  localparam int IdxLsb    = 3;           // registers sit 8 bytes apart

  localparam int                 MixDiv   = 1000;
  localparam logic [CoefW-1:0]   CoefMax  = 14'd9000;
  localparam logic [SumW-1:0]    SumClamp = 14'd255;
  localparam logic [ChanW-1:0]   ChanMax  = 8'd255;
  // ceil(2^32 / 1000): exact quotient for any dividend below 2^22
  localparam logic [RecipW-1:0]  Recip    = 23'd4294968;

  // Channel column and row positions.
  localparam int ChRed   = 0;
  localparam int ChGreen = 1;
  localparam int ChBlue  = 2;
  localparam int ChAlpha = 3;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [CoefW-1:0] coef_t;
  typedef logic [RowW-1:0]  row_t;
  typedef coef_t [NumChan-1:0] coef_row_t;

  typedef enum logic [IdxW-1:0] {
    REG_RED_ROW   = 3'd0,
    REG_GREEN_ROW = 3'd1,
    REG_BLUE_ROW  = 3'd2,
    REG_ALPHA_ROW = 3'd3,
    REG_WITH_ALPHA = 3'd4
  } reg_idx_t;

  // Coefficient matrix, indexed [output row][input column], plus pixel mode.
  typedef struct packed {
    coef_row_t [NumChan-1:0] coef;
    logic                    with_alpha;
  } cmm_cfg_t;

  // Coefficients above the legal maximum count as the maximum.
  function automatic coef_t sat_coef(input coef_t c);
    return (c > CoefMax) ? CoefMax : c;
  endfunction

  // Division by 1000 through a multiply by the rounded-up reciprocal.
  function automatic logic [QuotW-1:0] div_by_1000(input logic [ProdW-1:0] x);
    logic [RecipMulW-1:0] p;
    p = RecipMulW'(x) * RecipMulW'(Recip);
    return p[RecipSh +: QuotW];
  endfunction

  // Saturate a channel sum to the 8-bit range.
  function automatic chan_t clamp_chan(input logic [SumW-1:0] s);
    return (s > SumClamp) ? ChanMax : s[ChanW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cmm_if.sv -----
// ----------------------------------------------------------------------------
// Colour matrix mixer pixel channels
// Valid/ready interfaces carrying one input pixel and one mixed pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmm_in_if;
  logic           valid;
  logic           ready;
  cmm_pkg::chan_t red_in;
  cmm_pkg::chan_t green_in;
  cmm_pkg::chan_t blue_in;
  cmm_pkg::chan_t alpha_in;

  modport source(output valid, output red_in, output green_in, output blue_in,
                 output alpha_in, input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in,
               input alpha_in, output ready);
endinterface

interface cmm_out_if;
  logic           valid;
  logic           ready;
  cmm_pkg::chan_t red_out;
  cmm_pkg::chan_t green_out;
  cmm_pkg::chan_t blue_out;
  cmm_pkg::chan_t alpha_out;

  modport source(output valid, output red_out, output green_out, output blue_out,
                 output alpha_out, input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out,
               input alpha_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/cmm_regs.sv -----
// ----------------------------------------------------------------------------
// Colour matrix mixer register file
// APB-style register bank holding the four coefficient rows and pixel mode.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cmm_pkg::PaddrW-1:0]   paddr,
  input  wire logic [cmm_pkg::PdataW-1:0]   pwdata,
  output logic      [cmm_pkg::PdataW-1:0]   prdata,
  output logic                              pready,
  output cmm_pkg::cmm_cfg_t                 cfg
);
  import cmm_pkg::*;

  row_t     rows [NumChan];
  logic     with_alpha;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[IdxLsb +: IdxW]);

  // Register writes; unused addresses are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NumChan; r++) begin
        rows[r] <= RowW'(MixDiv) << (CoefW * r);
      end
      with_alpha <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_RED_ROW:    rows[ChRed]   <= pwdata[RowW-1:0];
        REG_GREEN_ROW:  rows[ChGreen] <= pwdata[RowW-1:0];
        REG_BLUE_ROW:   rows[ChBlue]  <= pwdata[RowW-1:0];
        REG_ALPHA_ROW:  rows[ChAlpha] <= pwdata[RowW-1:0];
        REG_WITH_ALPHA: with_alpha    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (idx)
      REG_RED_ROW:    prdata = PdataW'(rows[ChRed]);
      REG_GREEN_ROW:  prdata = PdataW'(rows[ChGreen]);
      REG_BLUE_ROW:   prdata = PdataW'(rows[ChBlue]);
      REG_ALPHA_ROW:  prdata = PdataW'(rows[ChAlpha]);
      REG_WITH_ALPHA: prdata = PdataW'(with_alpha);
      default:        prdata = '0;
    endcase
  end

  // Unpack the rows into the coefficient matrix.
  always_comb begin
    for (int r = 0; r < NumChan; r++) begin
      for (int c = 0; c < NumChan; c++) begin
        cfg.coef[r][c] = rows[r][c*CoefW +: CoefW];
      end
    end
    cfg.with_alpha = with_alpha;
  end

endmodule

`default_nettype wire

// ----- rtl/cmm_datapath.sv -----
// ----------------------------------------------------------------------------
// Colour matrix mixer datapath
// Four-stage pipeline: pixel register, products, divide by 1000, sum and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmm_pkg::cmm_cfg_t cfg,
  cmm_in_if.sink                 pix_in,
  cmm_out_if.source              pix_out
);
  import cmm_pkg::*;

  // Stage valids and load enables.
  logic v1, v2, v3, vo;
  logic ld1, ld2, ld3, ld_o;

  // Stage payloads.
  chan_t              ch [NumChan];
  logic [ProdW-1:0]   prod [NumChan][NumChan];
  logic [ProdW-1:0]   prod_next [NumChan][NumChan];
  logic               wa2, wa3;
  logic [QuotW-1:0]   quot [NumChan][NumChan];
  logic [QuotW-1:0]   quot_next [NumChan][NumChan];
  chan_t              res [NumChan];
  chan_t              res_next [NumChan];

  // Each stage loads when it is empty or its contents move on.
  assign ld_o = !vo || pix_out.ready;
  assign ld3  = !v3 || ld_o;
  assign ld2  = !v2 || ld3;
  assign ld1  = !v1 || ld2;
  assign pix_in.ready = ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (ld1)  v1 <= pix_in.valid;
      if (ld2)  v2 <= v1;
      if (ld3)  v3 <= v2;
      if (ld_o) vo <= v3;
    end
  end

  // Pixel input register.
  always_ff @(posedge clk) begin
    if (ld1) begin
      ch[ChRed]   <= pix_in.red_in;
      ch[ChGreen] <= pix_in.green_in;
      ch[ChBlue]  <= pix_in.blue_in;
      ch[ChAlpha] <= pix_in.alpha_in;
    end
  end

  // Channel times saturated coefficient; the alpha column drops out in RGB mode.
  always_comb begin
    for (int r = 0; r < NumChan; r++) begin
      for (int c = 0; c < NumChan; c++) begin
        prod_next[r][c] = ProdW'(ch[c]) * ProdW'(sat_coef(cfg.coef[r][c]));
        if (c == ChAlpha && !cfg.with_alpha) begin
          prod_next[r][c] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      prod <= prod_next;
      wa2  <= cfg.with_alpha;
    end
  end

  // Each term is truncated on its own by the divide.
  always_comb begin
    for (int r = 0; r < NumChan; r++) begin
      for (int c = 0; c < NumChan; c++) begin
        quot_next[r][c] = div_by_1000(prod[r][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      quot <= quot_next;
      wa3  <= wa2;
    end
  end

  // Row sums, clamped; alpha output is forced to zero in RGB mode.
  always_comb begin
    logic [SumW-1:0] sum;
    for (int r = 0; r < NumChan; r++) begin
      sum = '0;
      for (int c = 0; c < NumChan; c++) begin
        sum = sum + SumW'(quot[r][c]);
      end
      res_next[r] = clamp_chan(sum);
    end
    if (!wa3) begin
      res_next[ChAlpha] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_o) begin
      res <= res_next;
    end
  end

  assign pix_out.valid     = vo;
  assign pix_out.red_out   = res[ChRed];
  assign pix_out.green_out = res[ChGreen];
  assign pix_out.blue_out  = res[ChBlue];
  assign pix_out.alpha_out = res[ChAlpha];

  // Reset empties every stage of the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !v1 && !v2 && !v3 && !vo)
    else $error("pipeline not empty after reset");

  // An accepted pixel always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> v1)
    else $error("accepted pixel lost at input register");

  // A finished sum moves into the result register when it is free.
  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    (v3 && ld_o) |=> vo)
    else $error("quotient stage dropped an item");

  // A blocked quotient stage keeps its contents.
  a_quot_holds: assert property (@(posedge clk) disable iff (rst)
    (v3 && !ld_o) |=> v3 && $stable(wa3))
    else $error("quotient stage changed while stalled");

endmodule

`default_nettype wire

// ----- rtl/color_matrix_mixer.sv -----
// ----------------------------------------------------------------------------
// Colour matrix mixer
// Applies a 4x4 coefficient matrix to one 8-bit ARGB or RGB pixel per clock.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while its output is not stalled. Each
// pixel passes a pixel register, a product register holding the sixteen
// channel-by-coefficient terms, a quotient register after the divide by 1000,
// and the result register that holds the clamped sums. Each stage moves on as
// soon as the next one is free, so a stalled output only blocks the input once
// all four stages are full. Coefficient rows lie at byte addresses 0, 8, 16 and
// 24 (red, green, blue, alpha outputs), each holding four 14-bit fields for the
// red, green, blue and alpha inputs, lowest first; the pixel mode bit lies at
// address 32. Registers should be written only while no pixel is in flight.
`default_nettype none

module color_matrix_mixer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cmm_pkg::PaddrW-1:0]  paddr,
  input  wire logic [cmm_pkg::PdataW-1:0]  pwdata,
  output logic      [cmm_pkg::PdataW-1:0]  prdata,
  output logic                             pready,
  cmm_in_if.sink                           in_pix,
  cmm_out_if.source                        out_pix
);
  import cmm_pkg::*;

  cmm_cfg_t cfg;

  // Configuration registers.
  cmm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Mixing pipeline.
  cmm_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pix_in  (in_pix),
    .pix_out (out_pix)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Colour matrix mixer testbench
// Drives pixel requests with bursts and gaps, stalls the result side on
// changing patterns, programmes the coefficient matrix over the register port
// between phases, and checks every mixed pixel against a local prediction.
// ----------------------------------------------------------------------------

import cmm_pkg::*;

typedef struct packed {
  chan_t red;
  chan_t green;
  chan_t blue;
  chan_t alpha;
} pix_t;

// Holds a copy of the coefficient matrix and the pixel mode, predicts the
// mixed pixel for each accepted request and checks results in order.
class pixel_mix_scoreboard;
  row_t  rows[NumChan];
  logic  with_alpha;
  pix_t  expected_pixels[$];
  int    errors;

  function void reset_regs();
    for (int r = 0; r < NumChan; r++) begin
      rows[r] = row_t'(MixDiv) << (r * CoefW);
    end
    with_alpha = 1'b0;
    errors = 0;
  endfunction

  // Mirror a register write; unknown indexes change nothing.
  function void set_reg(logic [IdxW-1:0] idx, logic [PdataW-1:0] wdata);
    case (idx)
      REG_RED_ROW:    rows[ChRed]   = wdata[RowW-1:0];
      REG_GREEN_ROW:  rows[ChGreen] = wdata[RowW-1:0];
      REG_BLUE_ROW:   rows[ChBlue]  = wdata[RowW-1:0];
      REG_ALPHA_ROW:  rows[ChAlpha] = wdata[RowW-1:0];
      REG_WITH_ALPHA: with_alpha    = wdata[0];
      default: ;
    endcase
  endfunction

  // One output channel: truncated terms summed, then clamped.
  function chan_t mix_channel(row_t row, pix_t p, bit use_alpha);
    int unsigned chan_val[NumChan];
    int unsigned coef;
    int unsigned total;
    int          n;
    chan_val[ChRed]   = 32'(p.red);
    chan_val[ChGreen] = 32'(p.green);
    chan_val[ChBlue]  = 32'(p.blue);
    chan_val[ChAlpha] = 32'(p.alpha);
    total = 0;
    n = use_alpha ? NumChan : ChAlpha;
    for (int k = 0; k < n; k++) begin
      coef = 32'(row[k*CoefW +: CoefW]);
      if (coef > CoefMax) coef = 32'(CoefMax);
      total += chan_val[k] * coef / MixDiv;
    end
    return (total > ChanMax) ? ChanMax : chan_t'(total);
  endfunction

  function void note_request(pix_t p);
    pix_t mixed;
    mixed.red   = mix_channel(rows[ChRed], p, with_alpha);
    mixed.green = mix_channel(rows[ChGreen], p, with_alpha);
    mixed.blue  = mix_channel(rows[ChBlue], p, with_alpha);
    mixed.alpha = with_alpha ? mix_channel(rows[ChAlpha], p, 1'b1) : '0;
    expected_pixels.push_back(mixed);
  endfunction

  function void compare_field(string name, chan_t exp_val, chan_t act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  function void check_result(pix_t got);
    pix_t exp_pix;
    if (expected_pixels.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    exp_pix = expected_pixels.pop_front();
    compare_field("red_out", exp_pix.red, got.red);
    compare_field("green_out", exp_pix.green, got.green);
    compare_field("blue_out", exp_pix.blue, got.blue);
    compare_field("alpha_out", exp_pix.alpha, got.alpha);
  endfunction

  function int pending();
    return expected_pixels.size();
  endfunction
endclass

module tb;

  localparam int StallLimit  = 3000;  // well above the long hold plus a phase change
  localparam int LongHold    = 150;
  localparam int DrainCycles = 8;     // four-stage pipeline plus margin
  localparam int RandPhases  = 8;
  localparam int PhaseItems  = 200;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [PdataW-1:0]   pwdata;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  cmm_in_if  in_pix();
  cmm_out_if out_pix();

  pixel_mix_scoreboard sb;
  int  burst_left;
  int  long_holds_asked = 0;
  int  idle_cycles = 0;

  color_matrix_mixer uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_pix  (in_pix),
    .out_pix (out_pix)
  );

  always #4 clk = ~clk;

  // Register write: setup, access until pready, then idle with psel low.
  task automatic reg_write(input logic [IdxW-1:0] idx, input logic [PdataW-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(idx) << IdxLsb;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, wdata);
    @(posedge clk);
  endtask

  function automatic logic [PdataW-1:0] pack_row(int c0, int c1, int c2, int c3);
    return PdataW'({coef_t'(c3), coef_t'(c2), coef_t'(c1), coef_t'(c0)});
  endfunction

  task automatic write_matrix(input logic [PdataW-1:0] red_row, input logic [PdataW-1:0] green_row,
                              input logic [PdataW-1:0] blue_row,
                              input logic [PdataW-1:0] alpha_row, input logic mode);
    reg_write(REG_RED_ROW, red_row);
    reg_write(REG_GREEN_ROW, green_row);
    reg_write(REG_BLUE_ROW, blue_row);
    reg_write(REG_ALPHA_ROW, alpha_row);
    reg_write(REG_WITH_ALPHA, {$urandom(), $urandom()} & ~PdataW'(1) | PdataW'(mode));
  endtask

  // Offer one request and wait for it to be taken; start a gap at the end
  // of each burst, when its random length is not zero.
  task automatic send_pixel(input pix_t p);
    int gap;
    in_pix.valid    <= 1'b1;
    in_pix.red_in   <= p.red;
    in_pix.green_in <= p.green;
    in_pix.blue_in  <= p.blue;
    in_pix.alpha_in <= p.alpha;
    do @(posedge clk); while (!in_pix.ready);
    sb.note_request(p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_pix.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Stop offering and let every expected pixel come out before a write.
  task automatic drain();
    in_pix.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic chan_t rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ChanMax;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Coefficients lean small so that sums do not always clamp.
  function automatic int rand_coef();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return CoefMax;
      2:       return $urandom_range(int'(CoefMax) + 1, (1 << CoefW) - 1);
      3, 4, 5: return $urandom_range(0, 400);
      6, 7, 8: return $urandom_range(0, 1500);
      default: return $urandom_range(0, (1 << CoefW) - 1);
    endcase
  endfunction

  function automatic logic [PdataW-1:0] rand_row();
    logic [PdataW-1:0] r;
    r = pack_row(rand_coef(), rand_coef(), rand_coef(), rand_coef());
    r[PdataW-1:RowW] = (PdataW-RowW)'($urandom());
    return r;
  endfunction

  // Result side: stall patterns in segments, with one long hold on request.
  initial begin : receiver
    int seg;
    int mode;
    int period;
    int holds_done;
    holds_done = 0;
    out_pix.ready <= 1'b0;
    forever begin
      if (long_holds_asked > holds_done) begin
        holds_done++;
        out_pix.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      seg    = $urandom_range(10, 80);
      mode   = $urandom_range(0, 3);
      period = $urandom_range(2, 5);
      for (int k = 0; k < seg; k++) begin
        case (mode)
          0:       out_pix.ready <= 1'b1;
          1:       out_pix.ready <= 1'($urandom_range(0, 1));
          2:       out_pix.ready <= (k % period) != 0;
          default: out_pix.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    if (!rst && out_pix.valid && out_pix.ready) begin
      sb.check_result({out_pix.red_out, out_pix.green_out, out_pix.blue_out,
                       out_pix.alpha_out});
    end
  end

  // Watchdog on cycles with no request or result moving.
  always @(posedge clk) begin
    if ((in_pix.valid && in_pix.ready) || (out_pix.valid && out_pix.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    pix_t directed_pix[5];
    pix_t p;
    logic [PdataW-1:0] sat_row;

    sb = new;
    sb.reset_regs();
    burst_left      = 0;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_pix.valid    <= 1'b0;
    in_pix.red_in   <= '0;
    in_pix.green_in <= '0;
    in_pix.blue_in  <= '0;
    in_pix.alpha_in <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Channel extremes and alternating bit patterns.
    directed_pix[0] = '{8'h00, 8'h00, 8'h00, 8'h00};
    directed_pix[1] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    directed_pix[2] = '{8'h55, 8'hAA, 8'h55, 8'hAA};
    directed_pix[3] = '{8'hAA, 8'h55, 8'hAA, 8'h55};
    directed_pix[4] = '{8'hFF, 8'h00, 8'h80, 8'h07};

    // Reset matrix, RGB mode.
    foreach (directed_pix[i]) send_pixel(directed_pix[i]);
    drain();

    // ARGB with distinct rows, so that the alpha row is told apart from blue.
    write_matrix(pack_row(1000, 0, 0, 500), pack_row(0, 1000, 0, 250),
                 pack_row(0, 0, 1000, 0), pack_row(100, 200, 300, 1000), 1'b1);
    foreach (directed_pix[i]) send_pixel(directed_pix[i]);
    drain();

    // Coefficients around the limit: saturation above it, exact at it.
    write_matrix(pack_row(9000, 9001, 8999, 16383), pack_row(16383, 9000, 0, 1),
                 pack_row(1, 2, 3, 9001), pack_row(9001, 0, 16383, 999), 1'b1);
    foreach (directed_pix[i]) send_pixel(directed_pix[i]);
    drain();

    // All fields at their top bits and stray upper data bits, RGB mode.
    sat_row = '1;
    write_matrix(sat_row, sat_row, sat_row, sat_row, 1'b0);
    foreach (directed_pix[i]) send_pixel(directed_pix[i]);
    drain();

    // All zero with ARGB; writes to unused indexes must change nothing.
    write_matrix('0, '0, '0, '0, 1'b1);
    reg_write(IdxW'(int'(REG_WITH_ALPHA) + 1), '1);
    reg_write(IdxW'(int'(REG_WITH_ALPHA) + 3), '1);
    foreach (directed_pix[i]) send_pixel(directed_pix[i]);
    drain();

    // Random matrices, both pixel modes, random pixels.
    for (int ph = 0; ph < RandPhases; ph++) begin
      write_matrix(rand_row(), rand_row(), rand_row(), rand_row(),
                   ph[0] ^ 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0) begin
        reg_write(IdxW'($urandom_range(int'(REG_WITH_ALPHA) + 1, (1 << IdxW) - 1)),
                  {$urandom(), $urandom()});
      end
      if (ph == 1 || ph == 5) long_holds_asked++;
      for (int i = 0; i < PhaseItems; i++) begin
        p.red   = rand_chan();
        p.green = rand_chan();
        p.blue  = rand_chan();
        p.alpha = rand_chan();
        send_pixel(p);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
